/* rtl/spoe_pkg.sv */
// ----------------------------------------------------------------------------
// spoe_pkg
// Shared types, constants and helpers of the sonar path offset estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package spoe_pkg;

	localparam int SINE_TERMS_DEF = 5;

	localparam logic [9:0] INTERVAL_RST = 10'd100;
	localparam logic [9:0] WIDTH_RST    = 10'd200;

	localparam logic [7:0]  NO_ECHO   = 8'd255;
	localparam logic [11:0] FIELD_MAX = 12'd4095;

	// Q24 constants
	localparam logic [24:0] Q_ONE     = 25'd16777216;
	localparam logic [31:0] K1_Q      = 32'd11712706;
	localparam logic [31:0] K2_Q      = 32'd14640883;
	localparam logic [26:0] HALF_PI_Q = 27'd26353589;
	localparam logic [26:0] PI_Q      = 27'd52707179;

	localparam logic [31:0] MEGA      = 32'd1000000;
	localparam logic [31:0] TWO_KILO  = 32'd2000;

	typedef enum logic [1:0] {
		STATUS_NONE     = 2'd0,
		STATUS_OFF_PATH = 2'd1,
		STATUS_ON_PATH  = 2'd2
	} status_t;

	typedef enum logic {
		REG_INTERVAL = 1'b0,
		REG_WIDTH    = 1'b1
	} reg_index_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_P,
		ST_PP,
		ST_DS,
		ST_DM,
		ST_T,
		ST_DEN,
		ST_CMP,
		ST_DIV,
		ST_CM,
		ST_C2,
		ST_K1,
		ST_K2,
		ST_X,
		ST_X2,
		ST_TS0,
		ST_TACC,
		ST_TDIV0,
		ST_TNEXT,
		ST_OFF,
		ST_OFFL,
		ST_RAD,
		ST_SQ0,
		ST_SQ,
		ST_SQR,
		ST_FIN
	} state_t;

	// Q24 product rounded half up
	function automatic logic [39:0] qround(input logic [63:0] v);
		logic [63:0] s;
		s = v + 64'd8388608;
		return s[63:24];
	endfunction

	// factorial step (2k+2)(2k+3) of the Taylor sine
	function automatic logic [10:0] fact_step(input logic [3:0] k);
		logic [10:0] a;
		logic [10:0] b;
		a = {6'd0, k, 1'b0} + 11'd2;
		b = {6'd0, k, 1'b0} + 11'd3;
		return 11'(a * b);
	endfunction

endpackage

`default_nettype wire

/* rtl/sonar_path_offset_estimator.sv */
// ----------------------------------------------------------------------------
// sonar_path_offset_estimator
// Estimates lateral offset and impact distance of a sonar target.
// ----------------------------------------------------------------------------
// Items that give no estimate (first item, interval not elapsed, no echo, zero
// range or zero travel) return their result in the cycle after acceptance. An
// item that is evaluated keeps the block busy, the cosine division skipped
// when the cosine saturates and the impact root when none is needed, and its
// result follows as the block returns to idle: a single 32x32 multiplier and
// one restoring divider are shared between the steps, the divider spending 25
// steps on the cosine and 32 steps on each Taylor term but the last, and the
// impact root takes 12 more steps. One item is in work at a time; in_stall
// is high while it is.
`default_nettype none

module sonar_path_offset_estimator
	import spoe_pkg::*;
#(
	parameter int SINE_TERMS = SINE_TERMS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [9:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] time_ms,
	input  wire logic [7:0]  sonar_range_cm,
	input  wire logic [12:0] speed_cm_per_s,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [11:0]      path_offset,
	output logic [11:0]      impact_distance
);

	localparam int KW = (SINE_TERMS > 1) ? $clog2(SINE_TERMS) : 1;

	state_t state_q, state_d;

	logic [9:0]  interval_q;
	logic [9:0]  width_q;
	logic        have_q;
	logic [7:0]  prev_q;
	logic [31:0] last_q;

	logic [7:0]  r1_q, r2_q;
	logic [12:0] speed_q;
	logic [22:0] p_q;
	logic [46:0] pp_q;
	logic [47:0] mag_q;
	logic        neg_q;
	logic [41:0] den_q;
	logic [41:0] rem_q;
	logic [31:0] shin_q;
	logic [31:0] quo_q;
	logic [4:0]  div_cnt_q;
	logic        div_int_q;
	logic [24:0] cm_q;
	logic [25:0] x_q;
	logic [31:0] x2_q;
	logic [31:0] term_q;
	logic signed [31:0] acc_q;
	logic [KW-1:0] k_q;
	logic [19:0] off_q;
	logic [23:0] sq_rem_q, sq_root_q, sq_bit_q;
	logic [63:0] prod_q;

	logic        out_valid_q;
	status_t     status_q;
	logic [11:0] off_out_q, imp_out_q;
	status_t     res_status_q;
	logic [11:0] res_off_q, res_imp_q;

	logic [31:0] mul_a, mul_b;
	logic        in_accept, slot_free, elapsed, calc_go;
	logic [31:0] dt;
	logic [7:0]  dmag;
	logic [8:0]  dsum;
	logic [39:0] pr_q24;
	logic [42:0] div_shift;
	logic        div_ge, div_last;
	logic [41:0] div_sub;
	logic [63:0] off_sum;
	logic [19:0] off_w;
	logic [13:0] width16;
	logic [11:0] full;
	logic [10:0] fstep;
	logic [23:0] sq_try;
	logic signed [31:0] acc_next;
	logic [26:0] x_raw;
	logic [47:0] num_mag;
	logic        num_neg;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_accept = in_valid && !in_stall;

	assign dt      = time_ms - last_q;
	assign elapsed = dt >= {22'd0, interval_q};
	assign calc_go = sonar_range_cm != 8'd0 && speed_cm_per_s != 13'd0
		&& interval_q != 10'd0;

	assign dmag   = (r2_q >= r1_q) ? (r2_q - r1_q) : (r1_q - r2_q);
	assign dsum   = {1'b0, r2_q} + {1'b0, r1_q};
	assign pr_q24 = qround(prod_q);

	// law of cosines numerator sign and magnitude
	always_comb begin
		if (r1_q > r2_q) begin
			num_neg = prod_q[47:0] > {1'b0, pp_q};
			num_mag = num_neg ? (prod_q[47:0] - {1'b0, pp_q})
				: ({1'b0, pp_q} - prod_q[47:0]);
		end else begin
			num_neg = 1'b0;
			num_mag = {1'b0, pp_q} + prod_q[47:0];
		end
	end

	assign div_shift = {rem_q, shin_q[31]};
	assign div_ge    = div_shift >= {1'b0, den_q};
	assign div_sub   = 42'(div_shift - {1'b0, den_q});
	assign div_last  = div_int_q ? (div_cnt_q == 5'd31) : (div_cnt_q == 5'd24);

	assign fstep    = fact_step(4'(k_q));
	assign acc_next = k_q[0] ? (acc_q - $signed(term_q)) : (acc_q + $signed(term_q));

	always_comb begin
		if (neg_q) begin
			x_raw = (pr_q24 >= {13'd0, HALF_PI_Q}) ? 27'd0
				: (HALF_PI_Q - pr_q24[26:0]);
		end else begin
			x_raw = HALF_PI_Q + pr_q24[26:0];
		end
		if (x_raw > PI_Q) begin
			x_raw = PI_Q;
		end
	end

	assign off_sum = prod_q + 64'd524288;
	assign off_w   = off_sum[39:20];
	assign width16 = {width_q, 4'd0};
	assign full    = {r2_q, 4'd0};
	assign sq_try  = sq_root_q + sq_bit_q;

	// shared multiplier operand selection and next state
	always_comb begin
		mul_a   = 32'd0;
		mul_b   = 32'd0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && have_q && elapsed && sonar_range_cm != NO_ECHO
						&& calc_go) begin
					state_d = ST_P;
				end
			end
			ST_P: begin
				mul_a   = {19'd0, speed_q};
				mul_b   = {22'd0, interval_q};
				state_d = ST_PP;
			end
			ST_PP: begin
				mul_a   = {9'd0, prod_q[22:0]};
				mul_b   = {9'd0, prod_q[22:0]};
				state_d = ST_DS;
			end
			ST_DS: begin
				mul_a   = {24'd0, dmag};
				mul_b   = {23'd0, dsum};
				state_d = ST_DM;
			end
			ST_DM: begin
				mul_a   = MEGA;
				mul_b   = prod_q[31:0];
				state_d = ST_T;
			end
			ST_T: begin
				mul_a   = TWO_KILO;
				mul_b   = {24'd0, r2_q};
				state_d = ST_DEN;
			end
			ST_DEN: begin
				mul_a   = prod_q[31:0];
				mul_b   = {9'd0, p_q};
				state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = (mag_q >= {6'd0, prod_q[41:0]}) ? ST_C2 : ST_DIV;
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = div_int_q ? ST_TNEXT : ST_CM;
				end
			end
			ST_CM: state_d = ST_C2;
			ST_C2: begin
				mul_a   = {7'd0, cm_q};
				mul_b   = {7'd0, cm_q};
				state_d = ST_K1;
			end
			ST_K1: begin
				mul_a   = K1_Q;
				mul_b   = pr_q24[31:0];
				state_d = ST_K2;
			end
			ST_K2: begin
				mul_a   = {7'd0, cm_q};
				mul_b   = pr_q24[31:0] + K2_Q;
				state_d = ST_X;
			end
			ST_X: state_d = ST_X2;
			ST_X2: begin
				mul_a   = {6'd0, x_q};
				mul_b   = {6'd0, x_q};
				state_d = ST_TS0;
			end
			ST_TS0: state_d = ST_TACC;
			ST_TACC: begin
				mul_a   = term_q;
				mul_b   = x2_q;
				state_d = (k_q == KW'(SINE_TERMS - 1)) ? ST_OFF : ST_TDIV0;
			end
			ST_TDIV0: state_d = ST_DIV;
			ST_TNEXT: state_d = ST_TACC;
			ST_OFF: begin
				mul_a   = {24'd0, r2_q};
				mul_b   = (acc_q > 0) ? acc_q : 32'd0;
				state_d = ST_OFFL;
			end
			ST_OFFL: begin
				if ({6'd0, width16} < off_w) begin
					state_d = ST_FIN;
				end else if ({8'd0, full} > off_w) begin
					state_d = ST_RAD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_RAD: begin
				mul_a   = {20'd0, full - off_q[11:0]};
				mul_b   = {19'd0, {1'b0, full} + {1'b0, off_q[11:0]}};
				state_d = ST_SQ0;
			end
			ST_SQ0: state_d = ST_SQ;
			ST_SQ: begin
				if (sq_bit_q == 24'd1) begin
					state_d = ST_SQR;
				end
			end
			ST_SQR: state_d = ST_FIN;
			ST_FIN: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			interval_q  <= INTERVAL_RST;
			width_q     <= WIDTH_RST;
			have_q      <= 1'b0;
			prev_q      <= 8'd0;
			last_q      <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_INTERVAL: interval_q <= cfg_data;
					REG_WIDTH:    width_q    <= cfg_data;
					default:      interval_q <= interval_q;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_accept) begin
				if (!have_q) begin
					have_q <= 1'b1;
					prev_q <= sonar_range_cm;
					last_q <= time_ms;
				end else if (elapsed && sonar_range_cm != NO_ECHO) begin
					prev_q <= sonar_range_cm;
					last_q <= time_ms;
				end
				if (state_d == ST_IDLE) begin
					out_valid_q <= 1'b1;
				end
			end
			if (state_q == ST_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				r1_q    <= prev_q;
				r2_q    <= sonar_range_cm;
				speed_q <= speed_cm_per_s;
				if (in_accept) begin
					status_q  <= STATUS_NONE;
					off_out_q <= 12'd0;
					imp_out_q <= 12'd0;
				end
			end
			ST_PP: p_q <= prod_q[22:0];
			ST_DS: pp_q <= prod_q[46:0];
			ST_T: begin
				mag_q <= num_mag;
				neg_q <= num_neg;
			end
			ST_CMP: begin
				den_q     <= prod_q[41:0];
				rem_q     <= mag_q[41:0];
				shin_q    <= 32'd0;
				quo_q     <= 32'd0;
				div_cnt_q <= 5'd0;
				div_int_q <= 1'b0;
				cm_q      <= Q_ONE;
			end
			ST_DIV: begin
				rem_q     <= div_ge ? div_sub : div_shift[41:0];
				shin_q    <= {shin_q[30:0], 1'b0};
				quo_q     <= {quo_q[30:0], div_ge};
				div_cnt_q <= div_cnt_q + 5'd1;
			end
			ST_CM: cm_q <= 25'((quo_q[25:0] + 26'd1) >> 1);
			ST_X: x_q <= x_raw[25:0];
			ST_TS0: begin
				x2_q   <= pr_q24[31:0];
				term_q <= {6'd0, x_q};
				acc_q  <= 32'sd0;
				k_q    <= '0;
			end
			ST_TACC: acc_q <= acc_next;
			ST_TDIV0: begin
				shin_q    <= pr_q24[31:0] + {22'd0, fstep[10:1]};
				rem_q     <= 42'd0;
				den_q     <= {31'd0, fstep};
				quo_q     <= 32'd0;
				div_cnt_q <= 5'd0;
				div_int_q <= 1'b1;
			end
			ST_TNEXT: begin
				term_q <= quo_q;
				k_q    <= k_q + KW'(1);
			end
			ST_OFFL: begin
				off_q     <= off_w;
				res_off_q <= (off_w > {8'd0, FIELD_MAX}) ? FIELD_MAX : off_w[11:0];
				res_imp_q <= 12'd0;
				res_status_q <= ({6'd0, width16} < off_w) ? STATUS_OFF_PATH
					: STATUS_ON_PATH;
			end
			ST_SQ0: begin
				sq_rem_q  <= prod_q[23:0];
				sq_root_q <= 24'd0;
				sq_bit_q  <= 24'h400000;
			end
			ST_SQ: begin
				if (sq_rem_q >= sq_try) begin
					sq_rem_q  <= sq_rem_q - sq_try;
					sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
				end else begin
					sq_root_q <= sq_root_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			ST_SQR: begin
				if (sq_root_q + {23'd0, sq_rem_q > sq_root_q} > {12'd0, FIELD_MAX}) begin
					res_imp_q <= FIELD_MAX;
				end else begin
					res_imp_q <= 12'(sq_root_q + {23'd0, sq_rem_q > sq_root_q});
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					status_q  <= res_status_q;
					off_out_q <= res_off_q;
					imp_out_q <= res_imp_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign path_offset     = off_out_q;
	assign impact_distance = imp_out_q;

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while an item is in work");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STATUS_NONE) |-> (path_offset == 12'd0
			&& impact_distance == 12'd0))
		else $error("result without estimate carries nonzero fields");

	a_off_no_impact: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STATUS_OFF_PATH) |-> (impact_distance == 12'd0))
		else $error("off-path result carries an impact distance");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder out of range");

	a_frac_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !div_int_q) |-> (div_cnt_q <= 5'd24))
		else $error("cosine division ran too long");

endmodule

`default_nettype wire

/* tb/tb_sonar_path_offset_estimator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sonar_path_offset_estimator
// Self-checking bench: a directed table of sonar items, then random phases at
// several interval/width settings, each result checked against a fixed-point
// estimator with random idling and a long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sonar_path_offset_estimator;
	import spoe_pkg::*;

	localparam int  NTERMS    = SINE_TERMS_DEF;
	localparam int  SETTLE    = 400;
	localparam int  LIMIT     = 3000000;

	typedef struct packed {
		logic [1:0]  st;
		logic [11:0] off;
		logic [11:0] imp;
	} estimate_t;

	typedef struct {
		logic [31:0] t;
		logic [7:0]  rng;
		logic [12:0] spd;
		bit          typed;
		logic [1:0]  st;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_INTERVAL;
	logic [9:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] time_ms = '0;
	logic [7:0]  sonar_range_cm = '0;
	logic [12:0] speed_cm_per_s = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [11:0] path_offset;
	logic [11:0] impact_distance;

	sonar_path_offset_estimator DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// estimator state and register copies
	bit          have_first;
	logic [7:0]  prev_range;
	logic [31:0] last_time;
	logic [9:0]  cur_interval = INTERVAL_RST;
	logic [9:0]  cur_width    = WIDTH_RST;

	estimate_t   pending[$];
	int          errors, n_items, n_results, n_on, n_off;
	bit          quiet, rx_hold;
	longint      cycles;

	function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
		return (a * b + 64'd8388608) >> 24;
	endfunction

	function automatic logic [63:0] frac_div(logic [63:0] mag, logic [63:0] den);
		logic [63:0] q, r;
		q = 0;
		r = mag;
		for (int i = 0; i < 25; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return (q + 1) >> 1;
	endfunction

	function automatic longint sine_series(logic [63:0] x);
		logic [63:0] x2, term, f;
		longint acc;
		x2 = qmul(x, x);
		term = x;
		acc = 0;
		for (int k = 0; k < NTERMS; k++) begin
			f = (2 * k + 2) * (2 * k + 3);
			if (k % 2 == 0) acc += longint'(term);
			else acc -= longint'(term);
			term = (qmul(term, x2) + f / 2) / f;
		end
		return acc;
	endfunction

	function automatic logic [31:0] root_round(logic [31:0] n);
		logic [31:0] root, bitv, rem;
		root = 0;
		bitv = 32'h4000_0000;
		rem = n;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		if (rem > root) root++;
		return root;
	endfunction

	// advance the state for one accepted item and return its estimate
	function automatic estimate_t estimate_offset(logic [31:0] now, logic [7:0] r2,
			logic [12:0] spd);
		logic [7:0]  r1;
		logic [31:0] dt, imp;
		logic [63:0] p, den, mag, cm, prod, x, off16, full;
		longint      lr1, lr2, num, s;
		estimate_t   e;
		e = '0;
		if (!have_first) begin
			have_first = 1;
			prev_range = r2;
			last_time = now;
			return e;
		end
		dt = now - last_time;
		if (dt < cur_interval) return e;
		if (r2 == NO_ECHO) return e;
		r1 = prev_range;
		prev_range = r2;
		last_time = now;
		p = 64'(spd) * 64'(cur_interval);
		if (r2 == 0 || p == 0) return e;
		den = 64'd2000 * 64'(r2) * p;
		lr1 = r1;
		lr2 = r2;
		num = 64'sd1000000 * (lr2 * lr2 - lr1 * lr1) + longint'(p * p);
		mag = (num < 0) ? 64'(-num) : 64'(num);
		cm = (mag >= den) ? 64'(Q_ONE) : frac_div(mag, den);
		prod = qmul(cm, qmul(64'(K1_Q), qmul(cm, cm)) + 64'(K2_Q));
		if (num < 0) x = (prod >= HALF_PI_Q) ? 64'd0 : 64'(HALF_PI_Q) - prod;
		else x = 64'(HALF_PI_Q) + prod;
		if (x > PI_Q) x = 64'(PI_Q);
		s = sine_series(x);
		off16 = (s > 0) ? ((64'(r2) * 64'(s) + 64'h80000) >> 20) : 64'd0;
		if (off16 <= 64'(cur_width) * 16) begin
			full = 64'(r2) * 16;
			imp = 0;
			e.st = STATUS_ON_PATH;
			if (off16 < full) imp = root_round(32'(full * full - off16 * off16));
			e.imp = (imp > FIELD_MAX) ? FIELD_MAX : imp[11:0];
		end else begin
			e.st = STATUS_OFF_PATH;
		end
		e.off = (off16 > FIELD_MAX) ? FIELD_MAX : off16[11:0];
		return e;
	endfunction

	task automatic report_mismatch(string what, int exp_v, int got_v);
		$display("MISMATCH %s: expected %0d got %0d (result %0d)", what, exp_v, got_v,
			n_results);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		estimate_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				report_mismatch("unexpected result, status", -1, status);
			end else begin
				e = pending.pop_front();
				if (status !== e.st) report_mismatch("status", e.st, status);
				if (path_offset !== e.off) report_mismatch("path_offset", e.off, path_offset);
				if (impact_distance !== e.imp)
					report_mismatch("impact_distance", e.imp, impact_distance);
				if (e.st == STATUS_ON_PATH) n_on++;
				if (e.st == STATUS_OFF_PATH) n_off++;
			end
			n_results++;
		end
	end

	// receiver stalls: mostly short, a few long, one long hold-off on request
	initial begin
		int len;
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				out_stall = 1'b1;
				for (int c = 0; c < 3000; c++) @(negedge clk);
				rx_hold = 0;
				out_stall = 1'b0;
			end else if (quiet || $urandom_range(0, 9) < 6) begin
				out_stall = 1'b0;
			end else begin
				len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 300);
				out_stall = 1'b1;
				repeat (len - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// offer one item and hold it until accepted
	task automatic send_item(logic [31:0] t, logic [7:0] rng, logic [12:0] spd,
			bit typed, logic [1:0] st);
		estimate_t e;
		@(negedge clk);
		time_ms = t;
		sonar_range_cm = rng;
		speed_cm_per_s = spd;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		e = estimate_offset(t, rng, spd);
		if (typed) e = '{st: st, off: 12'd0, imp: 12'd0};
		pending.push_back(e);
		n_items++;
	endtask

	task automatic sender_gap();
		int len;
		len = 0;
		if (!quiet && $urandom_range(0, 9) >= 6)
			len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 120);
		if (len > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (len - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_register(reg_index_t idx, logic [9:0] val);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_INTERVAL) cur_interval = val;
		else cur_width = val;
	endtask

	task automatic random_phase(int count);
		logic [31:0] t;
		logic [7:0]  rng;
		logic [12:0] spd;
		int          pick;
		t = last_time;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) t += cur_interval + $urandom_range(0, 20);
			else if (pick < 88) t += $urandom_range(0, cur_interval);
			else if (pick < 95) t = $urandom;
			else t += $urandom_range(0, 3000);
			pick = $urandom_range(0, 99);
			if (pick < 5) rng = NO_ECHO;
			else if (pick < 8) rng = 8'd0;
			else if (pick < 50 && prev_range > 8 && prev_range < 247)
				rng = 8'(prev_range + $urandom_range(0, 16) - 8);
			else rng = 8'($urandom_range(1, 254));
			pick = $urandom_range(0, 99);
			if (pick < 5) spd = 13'd0;
			else if (pick < 25) spd = 13'($urandom);
			else spd = 13'($urandom_range(50, 3000));
			send_item(t, rng, spd, 1'b0, STATUS_NONE);
			sender_gap();
		end
	endtask

	row_t table_rows[] = '{
		'{32'd1000,        8'd255, 13'd0,    1, STATUS_NONE},  // first item stores no-echo
		'{32'd1050,        8'd100, 13'd500,  1, STATUS_NONE},  // interval not elapsed
		'{32'd1100,        8'd255, 13'd500,  1, STATUS_NONE},  // no echo
		'{32'd1100,        8'd100, 13'd500,  0, STATUS_NONE},
		'{32'd1200,        8'd0,   13'd500,  1, STATUS_NONE},  // zero range
		'{32'd1300,        8'd120, 13'd0,    1, STATUS_NONE},  // zero speed
		'{32'd1400,        8'd110, 13'd300,  0, STATUS_NONE},
		'{32'd1500,        8'd254, 13'd8191, 0, STATUS_NONE},
		'{32'd1600,        8'd1,   13'd1,    0, STATUS_NONE},
		'{32'd1700,        8'd254, 13'd1,    0, STATUS_NONE},
		'{32'd1800,        8'd1,   13'd8191, 0, STATUS_NONE},
		'{32'hFFFF_FFD0,   8'd50,  13'd100,  0, STATUS_NONE},
		'{32'h0000_0020,   8'd60,  13'd100,  1, STATUS_NONE},  // wrapped, too soon
		'{32'h0000_0040,   8'd60,  13'd200,  0, STATUS_NONE},
		'{32'h0000_0100,   8'd200, 13'd4000, 0, STATUS_NONE},
		'{32'h0000_0200,   8'd180, 13'd4000, 0, STATUS_NONE},
		'{32'hFFFF_FFFF,   8'd90,  13'd2500, 0, STATUS_NONE}
	};

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		quiet = 1;
		foreach (table_rows[i])
			send_item(table_rows[i].t, table_rows[i].rng, table_rows[i].spd,
				table_rows[i].typed, table_rows[i].st);
		quiet = 0;
		random_phase(300);

		write_register(REG_INTERVAL, 10'd1);
		write_register(REG_WIDTH, 10'd0);
		rx_hold = 1;
		random_phase(250);

		write_register(REG_INTERVAL, 10'd1000);
		write_register(REG_WIDTH, 10'd1023);
		random_phase(250);

		write_register(REG_INTERVAL, 10'd0);
		write_register(REG_WIDTH, 10'd512);
		random_phase(100);

		write_register(REG_INTERVAL, 10'($urandom_range(2, 999)));
		write_register(REG_WIDTH, 10'($urandom_range(1, 1022)));
		quiet = 1;
		random_phase(150);
		quiet = 0;
		random_phase(350);

		drain();
		$display("Ran %0d items over five register settings, %0d results checked", n_items,
			n_results);
		$display("Estimates seen: %0d on path, %0d off path", n_on, n_off);
		if (errors == 0 && pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
